// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro wraps one clocked concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion disabled while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hw/rtl/rgbk_pkg.sv =====
// Shared constants and types of the RGB 3x3 kernel filter.
// No dependencies.
package rgbk_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_LEFT   = 3'd3;
  localparam logic [2:0] REG_TOP    = 3'd4;
  localparam logic [2:0] REG_RIGHT  = 3'd5;
  localparam logic [2:0] REG_BOTTOM = 3'd6;

  // filter modes
  localparam logic [1:0] MODE_EDGE    = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_BOX     = 2'd2;
  localparam logic [1:0] MODE_GAUSS   = 2'd3;

  // reciprocal of 18 in 16 fractional bits
  localparam logic [11:0] RECIP_18 = 12'd3641;

  typedef struct packed {
    logic        last;
    logic [9:0]  col;
    logic [11:0] row;
    logic [23:0] px;
  } result_t;
endpackage

// ===== hw/rtl/rgb_3x3_kernel_filter.sv =====
// RGB 3x3 kernel filter: top level with line memory, window, filter and output FIFO.
// Depends on rgbk_pkg.
// The word that completes a result passes stages 1, 2 and 3 and the output FIFO;
//   a filtered pixel is completed one row and one column after it arrives.
// Throughput: one pixel per cycle while s_tready is high, set by the single line
//   memory read-modify-write per pixel; FIFO drains one result per cycle if m_tready.
// Reset: synchronous, clears counters, pipeline valids and FIFO; the line
//   memory is not cleared, and configuration registers take their reset values.
module rgb_3x3_kernel_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // red_out, green_out, blue_out, pixel_row[35:24],
                                 // pixel_column[45:36], zero pad
  output logic        m_tlast,   // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import rgbk_pkg::*;

  // configuration registers
  logic [10:0] image_width, region_left, region_right;
  logic [12:0] image_height, region_top, region_bottom;
  logic [1:0]  filter_mode;

  assign cfg_ready = 1'b1;

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd1024;
      image_height  <= 13'd1;
      filter_mode   <= MODE_EDGE;
      region_left   <= 11'd0;
      region_top    <= 13'd0;
      region_right  <= 11'd1024;
      region_bottom <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data[10:0];
        REG_HEIGHT: image_height  <= cfg_data;
        REG_MODE:   filter_mode   <= cfg_data[1:0];
        REG_LEFT:   region_left   <= cfg_data[10:0];
        REG_TOP:    region_top    <= cfg_data;
        REG_RIGHT:  region_right  <= cfg_data[10:0];
        REG_BOTTOM: region_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  assign w_eff = (image_width == 11'd0) ? 11'd1 :
                 (image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == 13'd0) ? 13'd1 :
                 (image_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : image_height;

  // pipeline valids and FIFO fill
  logic              s1_valid, s2_valid, s3_valid;
  logic [FIFO_AW:0]  fifo_cnt;
  logic [FIFO_AW+2:0] reserve;
  logic              accept;

  // hold off input while the FIFO could overflow with words in flight
  assign reserve  = (FIFO_AW+3)'(fifo_cnt)
                  + (FIFO_AW+3)'(3 * ({2'b0, s1_valid} + {2'b0, s2_valid} + {2'b0, s3_valid}))
                  + (FIFO_AW+3)'(3);
  assign s_tready = (reserve <= (FIFO_AW+3)'(FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;

  // raster counters
  logic [9:0]  col_cnt;
  logic [11:0] row_cnt;
  logic        restart, c_last, r_last;
  logic [9:0]  c0;
  logic [11:0] r0;

  assign restart = ({1'b0, col_cnt} >= w_eff) || ({1'b0, row_cnt} >= h_eff);
  assign c0      = restart ? 10'd0 : col_cnt;
  assign r0      = restart ? 12'd0 : row_cnt;
  assign c_last  = ({1'b0, c0} == w_eff - 11'd1);
  assign r_last  = ({1'b0, r0} == h_eff - 13'd1);

  // advance counters on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= 10'd0;
      row_cnt <= 12'd0;
    end else if (accept) begin
      if (c_last) begin
        col_cnt <= 10'd0;
        row_cnt <= r_last ? 12'd0 : r0 + 12'd1;
      end else begin
        col_cnt <= c0 + 10'd1;
      end
    end
  end

  // stage 1 registers
  logic [9:0]  s1_c;
  logic [11:0] s1_r;
  logic        s1_clast, s1_rlast;
  logic [23:0] s1_cur;
  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] mem_q, byp_data, line;
  logic        byp;
  logic [23:0] line_up, line_mid;

  assign line     = byp ? byp_data : mem_q;
  assign line_up  = line[47:24];
  assign line_mid = line[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // capture word and forward the write of the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c     <= c0;
      s1_r     <= r0;
      s1_clast <= c_last;
      s1_rlast <= r_last;
      s1_cur   <= s_tdata;
      byp      <= s1_valid && (s1_c == c0);
      byp_data <= {line_mid, s1_cur};
    end
  end

  // line memory: read at accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_c[ADDR_W-1:0]] <= {line_mid, s1_cur};
    end
    if (accept) begin
      mem_q <= line_mem[c0[ADDR_W-1:0]];
    end
  end

  // window and stage 2 descriptors
  logic [23:0] win [9];
  logic        a_v, a_in, b_v, c_v, c_lastpx;
  logic [23:0] a_px, b_px, c_px;
  logic [11:0] a_row, b_row, c_row;
  logic [9:0]  a_col, b_col, c_col;
  logic [11:0] s1_orow;
  logic [9:0]  s1_ocol;
  logic        s1_inside;

  assign s1_orow   = s1_r - 12'd1;
  assign s1_ocol   = s1_c - 10'd1;
  assign s1_inside = (s1_r >= 12'd2) && (s1_c >= 10'd2)
                  && ({1'b0, s1_orow} >= region_top) && ({1'b0, s1_orow} < region_bottom)
                  && ({1'b0, s1_ocol} >= region_left) && ({1'b0, s1_ocol} < region_right);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= 24'd0;
    end else begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        win[0] <= win[1]; win[1] <= win[2]; win[2] <= line_up;
        win[3] <= win[4]; win[4] <= win[5]; win[5] <= line_mid;
        win[6] <= win[7]; win[7] <= win[8]; win[8] <= s1_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      a_v      <= (s1_r >= 12'd1) && (s1_c >= 10'd1);
      a_in     <= s1_inside;
      a_px     <= win[5];
      a_row    <= s1_orow;
      a_col    <= s1_ocol;
      b_v      <= (s1_r >= 12'd1) && s1_clast;
      b_px     <= line_mid;
      b_row    <= s1_orow;
      b_col    <= s1_c;
      c_v      <= s1_rlast;
      c_px     <= s1_cur;
      c_row    <= s1_r;
      c_col    <= s1_c;
      c_lastpx <= s1_clast;
    end
  end

  // kernel sums per channel
  logic signed [13:0] sum [3];
  always_comb begin
    logic signed [13:0] crn, edg, ctr;
    for (int k = 0; k < 3; k++) begin
      crn = 14'(win[0][8*k +: 8]) + 14'(win[2][8*k +: 8])
          + 14'(win[6][8*k +: 8]) + 14'(win[8][8*k +: 8]);
      edg = 14'(win[1][8*k +: 8]) + 14'(win[3][8*k +: 8])
          + 14'(win[5][8*k +: 8]) + 14'(win[7][8*k +: 8]);
      ctr = 14'(win[4][8*k +: 8]);
      case (filter_mode)
        MODE_EDGE:    sum[k] = (ctr <<< 3) - crn - edg;
        MODE_SHARPEN: sum[k] = (ctr <<< 2) + ctr - edg;
        MODE_BOX:     sum[k] = crn + edg + ctr;
        MODE_GAUSS:   sum[k] = crn + (edg <<< 1) + (ctr <<< 2);
        default:      sum[k] = 14'sd0;
      endcase
    end
  end

  // stage 3 registers
  logic signed [13:0] s3_sum [3];
  result_t s3_a, s3_b, s3_c;
  logic    s3_av, s3_ain, s3_bv, s3_cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      for (int k = 0; k < 3; k++) s3_sum[k] <= sum[k];
      s3_av  <= a_v;
      s3_ain <= a_in;
      s3_bv  <= b_v;
      s3_cv  <= c_v;
      s3_a   <= '{last: 1'b0, col: a_col, row: a_row, px: a_px};
      s3_b   <= '{last: 1'b0, col: b_col, row: b_row, px: b_px};
      s3_c   <= '{last: c_lastpx, col: c_col, row: c_row, px: c_px};
    end
  end

  // divide and round half up in box and Gaussian modes; clamp in all modes
  logic [23:0] filt_px;
  always_comb begin
    logic [13:0] t;
    logic [25:0] prod;
    logic [12:0] q;
    for (int k = 0; k < 3; k++) begin
      t    = 14'(s3_sum[k]) + 14'(s3_sum[k]) + 14'd9;
      prod = 26'(t) * 26'(RECIP_18);
      case (filter_mode)
        MODE_BOX:   q = 13'(prod >> 16);
        MODE_GAUSS: q = 13'((s3_sum[k] + 14'sd8) >>> 4);
        default:    q = 13'(s3_sum[k]);
      endcase
      if (s3_sum[k] < 0)        filt_px[8*k +: 8] = 8'd0;
      else if (q > 13'd255)     filt_px[8*k +: 8] = 8'd255;
      else                      filt_px[8*k +: 8] = q[7:0];
    end
  end

  result_t res_a;
  always_comb begin
    res_a = s3_a;
    if (s3_ain) res_a.px = filt_px;
  end

  // output FIFO
  result_t fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head, tail;
  logic push_a, push_b, push_c, pop;
  logic [FIFO_AW-1:0] pos_b, pos_c;
  logic [1:0] push_n;

  assign push_a = s3_valid && s3_av;
  assign push_b = s3_valid && s3_bv;
  assign push_c = s3_valid && s3_cv;
  assign pos_b  = tail + FIFO_AW'(push_a);
  assign pos_c  = pos_b + FIFO_AW'(push_b);
  assign push_n = {1'b0, push_a} + {1'b0, push_b} + {1'b0, push_c};
  assign pop    = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      fifo_cnt <= '0;
    end else begin
      head     <= head + FIFO_AW'(pop);
      tail     <= tail + FIFO_AW'(push_n);
      fifo_cnt <= fifo_cnt + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) fifo[tail]  <= res_a;
    if (push_b) fifo[pos_b] <= s3_b;
    if (push_c) fifo[pos_c] <= s3_c;
  end

  result_t head_word;
  assign head_word = fifo[head];
  assign m_tvalid  = (fifo_cnt != '0);
  assign m_tdata   = {2'b00, head_word.col, head_word.row, head_word.px};
  assign m_tlast   = head_word.last;
endmodule

// ===== hw/rtl/rgbk_checker.sv =====
// Port-level checker for the RGB 3x3 kernel filter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rgbk_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_ready
);
  // whole output word including the last flag
  logic [48:0] out_word;
  assign out_word = {m_tlast, m_tdata};

  // output word holds while stalled
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(out_word), "stall broken")
  // output is empty right after reset
  `ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !m_tvalid, "output valid after reset")
  // configuration port never stalls
  `ASSERT_CLK(a_cfg_ready, cfg_ready, "configuration port not ready")
  // padding bits of the output word stay zero
  `ASSERT_CLK(a_pad_zero, m_tvalid |-> m_tdata[47:46] == 2'b00, "output pad bits set")
endmodule

bind rgb_3x3_kernel_filter rgbk_port_checker u_rgbk_checker (.*);
